>>> rtl/pn3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_pkg
// Request codes and fixed sizes shared by the 3D gradient noise block.
// ----------------------------------------------------------------------------
package pn3d_pkg;

    localparam int COORD_W = 24;   // 8.F unsigned coordinate
    localparam int IDX_W   = 8;    // permutation table index
    localparam int PERM_W  = 8;    // permutation table entry
    localparam int NOISE_W = 17;   // unsigned Q1.16 result
    localparam int OUT_FRAC = 16;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [PERM_W-1:0]  perm_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [NOISE_W-1:0] noise_t;

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    localparam noise_t NOISE_MAX = noise_t'(1) << OUT_FRAC;

endpackage

>>> rtl/perlin_noise_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise, one sample per cycle while out_stall does not
// hold a waiting result, with a loadable 256-entry permutation table.
// ----------------------------------------------------------------------------
// A request is either a load (writes one permutation entry, no result) or a
// query (x, y, z as unsigned 8.FRAC_BITS, answered by one noise_value in
// unsigned Q1.16, saturated to [0, 1]). The block accepts one request every
// cycle that the output side is not holding it back; the only stall source
// is a result waiting in the output register while out_stall is high. A
// query's result passes through nine register stages, the first
// loaded at acceptance: dependent table lookups (corner X/X+1,
// then A/B rows, then the eight cube corners), the fade polynomial
// running alongside as four multiply stages, then the three lerp
// levels and the output scaling. The permutation table
// is held as seven copies of a 256x8 synchronous RAM, one per lookup port
// pair: one copy for the first hash level, two for the second, four for
// the third. A load travels down the pipe with the queries and writes each
// copy when it passes that lookup level, so queries behind a load see it and
// queries ahead of it do not; no forwarding is needed. Entries that were
// never loaded read as garbage; load the whole table before querying.
// ----------------------------------------------------------------------------
module perlin_noise_3d #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  pn3d_pkg::idx_t     table_index,
    input  pn3d_pkg::perm_t    table_value,
    input  pn3d_pkg::coord_t   coord_x,
    input  pn3d_pkg::coord_t   coord_y,
    input  pn3d_pkg::coord_t   coord_z,
    output logic               out_valid,
    input  logic               out_stall,
    output pn3d_pkg::noise_t   noise_value
);
    import pn3d_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int GW = F + 3;        // gradient / lerp values, signed
    localparam int FW = F + 4;        // fade intermediates, unsigned
    localparam int MW = 2 * F + 4;    // fade products
    localparam int PW = 2 * F + 6;    // lerp products, signed
    localparam int OUT_D = F + 1 - OUT_FRAC;

    localparam logic [F:0]    ONE_S     = (F + 1)'(1) << F;
    localparam logic [FW-1:0] TEN_S     = FW'(10) << F;
    localparam logic [FW-1:0] FIFTEEN_S = FW'(15) << F;
    localparam logic [MW-1:0] HALF_M    = MW'(1) << (F - 1);
    localparam logic [PW-1:0] HALF_P    = PW'(1) << (F - 1);

    typedef logic [F-1:0]         frac_t;
    typedef logic [MW-1:0]        prod_t;
    typedef logic [FW-1:0]        fq_t;
    typedef logic [F:0]           fade_t;
    typedef logic signed [GW-1:0] gval_t;

    // ------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------
    function automatic prod_t fade_m(input frac_t t);
        fq_t k;
        k = FIFTEEN_S - ((FW'(t) << 2) + (FW'(t) << 1));
        return MW'(t) * MW'(k);
    endfunction

    function automatic fq_t fade_q(input fq_t q, input frac_t t);
        prod_t p;
        p = MW'(q) * MW'(t) + HALF_M;
        return p[MW-1:F];
    endfunction

    function automatic fq_t fade_q0(input prod_t m);
        prod_t r;
        r = m + HALF_M;
        return TEN_S - r[MW-1:F];
    endfunction

    function automatic gval_t grad(input perm_t h, input logic signed [F+1:0] x,
                                   input logic signed [F+1:0] y,
                                   input logic signed [F+1:0] z);
        gval_t uu;
        gval_t vv;
        uu = (h[3] == 1'b0) ? GW'(x) : GW'(y);
        if (h[3:2] == 2'b00)
            vv = GW'(y);
        else if (h[3:0] == 4'd12 || h[3:0] == 4'd14)
            vv = GW'(x);
        else
            vv = GW'(z);
        return (h[0] ? -uu : uu) + (h[1] ? -vv : vv);
    endfunction

    function automatic gval_t lerp(input fade_t w, input gval_t a, input gval_t b);
        logic signed [GW:0]   diff;
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] rnd;
        diff = (GW + 1)'(b) - (GW + 1)'(a);
        prod = PW'($signed({1'b0, w})) * PW'(diff);
        rnd  = (prod + $signed(HALF_P)) >>> F;
        return a + GW'(rnd);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe moves together
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    logic acc_ld;
    assign acc_ld = in_valid && adv && (req_type == REQ_LOAD);

    // ------------------------------------------------------------------
    // Permutation table copies
    // ------------------------------------------------------------------
    perm_t tbl0_mem [256];
    perm_t tbl1_mem [2][256];
    perm_t tbl2_mem [4][256];

    // stage registers
    logic  s1_vld_reg, s1_ld_reg;
    idx_t  s1_idx_reg;
    perm_t s1_val_reg;
    idx_t  s1_y_reg, s1_z_reg;
    frac_t s1_frac_reg [3];
    perm_t s1_px_reg, s1_px1_reg;

    logic  s2_vld_reg, s2_ld_reg;
    idx_t  s2_idx_reg;
    perm_t s2_val_reg;
    idx_t  s2_z_reg;
    frac_t s2_frac_reg [3];
    prod_t s2_m_reg [3];
    perm_t s2_p_reg [4];              // perm(A), perm(A+1), perm(B), perm(B+1)

    logic  s3_vld_reg;
    frac_t s3_frac_reg [3];
    fq_t   s3_q_reg [3];
    perm_t s3_hash_reg [8];

    logic  s4_vld_reg;
    frac_t s4_frac_reg [3];
    fq_t   s4_q_reg [3];
    gval_t s4_g_reg [8];

    logic  s5_vld_reg;
    fade_t s5_fade_reg [3];
    gval_t s5_g_reg [8];

    logic  s6_vld_reg;
    fade_t s6_v_reg, s6_w_reg;
    gval_t s6_l_reg [4];

    logic  s7_vld_reg;
    fade_t s7_w_reg;
    gval_t s7_l_reg [2];

    logic  s8_vld_reg;
    gval_t s8_res_reg;

    noise_t noise_reg;
    noise_t noise_next;

    // hash addresses
    idx_t a_addr, b_addr;
    idx_t c_addr [4];
    assign a_addr    = s1_px_reg + s1_y_reg;
    assign b_addr    = s1_px1_reg + s1_y_reg;
    assign c_addr[0] = s2_p_reg[0] + s2_z_reg;   // AA
    assign c_addr[1] = s2_p_reg[2] + s2_z_reg;   // BA
    assign c_addr[2] = s2_p_reg[1] + s2_z_reg;   // AB
    assign c_addr[3] = s2_p_reg[3] + s2_z_reg;   // BB

    idx_t x_int;
    assign x_int = idx_t'(coord_x >> F);

    // table writes follow the load down the pipe
    always_ff @(posedge clk)
    begin
        if (acc_ld)
            tbl0_mem[table_index] <= table_value;
        if (adv && s1_ld_reg)
        begin
            for (int c = 0; c < 2; c++)
                tbl1_mem[c][s1_idx_reg] <= s1_val_reg;
        end
        if (adv && s2_ld_reg)
        begin
            for (int c = 0; c < 4; c++)
                tbl2_mem[c][s2_idx_reg] <= s2_val_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s1_ld_reg     <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s2_ld_reg     <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s8_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid && (req_type == REQ_QUERY);
            s1_ld_reg     <= acc_ld;
            s2_vld_reg    <= s1_vld_reg;
            s2_ld_reg     <= s1_ld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            s8_vld_reg    <= s7_vld_reg;
            out_valid_reg <= s8_vld_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: first hash lookup
            s1_idx_reg     <= table_index;
            s1_val_reg     <= table_value;
            s1_y_reg       <= idx_t'(coord_y >> F);
            s1_z_reg       <= idx_t'(coord_z >> F);
            s1_frac_reg[0] <= coord_x[F-1:0];
            s1_frac_reg[1] <= coord_y[F-1:0];
            s1_frac_reg[2] <= coord_z[F-1:0];
            s1_px_reg      <= tbl0_mem[x_int];
            s1_px1_reg     <= tbl0_mem[x_int + idx_t'(1)];

            // stage 2: A and B rows, fade first product
            s2_idx_reg  <= s1_idx_reg;
            s2_val_reg  <= s1_val_reg;
            s2_z_reg    <= s1_z_reg;
            s2_p_reg[0] <= tbl1_mem[0][a_addr];
            s2_p_reg[1] <= tbl1_mem[0][a_addr + idx_t'(1)];
            s2_p_reg[2] <= tbl1_mem[1][b_addr];
            s2_p_reg[3] <= tbl1_mem[1][b_addr + idx_t'(1)];
            for (int i = 0; i < 3; i++)
            begin
                s2_frac_reg[i] <= s1_frac_reg[i];
                s2_m_reg[i]    <= fade_m(s1_frac_reg[i]);
            end

            // stage 3: corner hashes, fade second product
            for (int c = 0; c < 4; c++)
            begin
                s3_hash_reg[c]     <= tbl2_mem[c][c_addr[c]];
                s3_hash_reg[c + 4] <= tbl2_mem[c][c_addr[c] + idx_t'(1)];
            end
            for (int i = 0; i < 3; i++)
            begin
                s3_frac_reg[i] <= s2_frac_reg[i];
                s3_q_reg[i]    <= fade_q(fade_q0(s2_m_reg[i]), s2_frac_reg[i]);
            end

            // stage 4: gradients, fade third product
            for (int i = 0; i < 3; i++)
            begin
                s4_frac_reg[i] <= s3_frac_reg[i];
                s4_q_reg[i]    <= fade_q(s3_q_reg[i], s3_frac_reg[i]);
            end
            for (int c = 0; c < 8; c++)
            begin
                s4_g_reg[c] <= grad(s3_hash_reg[c],
                    c[0] ? $signed({2'b11, s3_frac_reg[0]}) : $signed({2'b00, s3_frac_reg[0]}),
                    c[1] ? $signed({2'b11, s3_frac_reg[1]}) : $signed({2'b00, s3_frac_reg[1]}),
                    c[2] ? $signed({2'b11, s3_frac_reg[2]}) : $signed({2'b00, s3_frac_reg[2]}));
            end

            // stage 5: last fade step, clamp to one
            for (int i = 0; i < 3; i++)
            begin
                fq_t qf;
                qf = fade_q(s4_q_reg[i], s4_frac_reg[i]);
                s5_fade_reg[i] <= (qf > FW'(ONE_S)) ? ONE_S : qf[F:0];
            end
            for (int c = 0; c < 8; c++)
                s5_g_reg[c] <= s4_g_reg[c];

            // stage 6..8: trilinear blend
            for (int k = 0; k < 4; k++)
                s6_l_reg[k] <= lerp(s5_fade_reg[0], s5_g_reg[2 * k], s5_g_reg[2 * k + 1]);
            s6_v_reg <= s5_fade_reg[1];
            s6_w_reg <= s5_fade_reg[2];

            s7_l_reg[0] <= lerp(s6_v_reg, s6_l_reg[0], s6_l_reg[1]);
            s7_l_reg[1] <= lerp(s6_v_reg, s6_l_reg[2], s6_l_reg[3]);
            s7_w_reg    <= s6_w_reg;

            s8_res_reg <= lerp(s7_w_reg, s7_l_reg[0], s7_l_reg[1]);

            noise_reg <= noise_next;
        end
    end

    // ------------------------------------------------------------------
    // Output scaling: (res + 1) / 2, clamp, rescale to Q1.16
    // ------------------------------------------------------------------
    gval_t            biased;
    logic [F+1:0]     val;
    noise_t           scaled;
    assign biased = s8_res_reg + GW'(ONE_S);

    always_comb
    begin
        if (biased < 0)
            val = '0;
        else if (biased > $signed(GW'(ONE_S) << 1))
            val = (F + 2)'(ONE_S) << 1;
        else
            val = biased[F+1:0];
    end

    generate
        if (OUT_D > 0)
        begin : g_shr
            logic [F+2:0] rsum;
            assign rsum   = {1'b0, val} + ((F + 3)'(1) << (OUT_D - 1));
            assign scaled = NOISE_W'(rsum >> OUT_D);
        end
        else if (OUT_D == 0)
        begin : g_same
            assign scaled = NOISE_W'(val);
        end
        else
        begin : g_shl
            assign scaled = NOISE_W'({val, {(-OUT_D){1'b0}}});
        end
    endgenerate

    assign noise_next  = (scaled > NOISE_MAX) ? NOISE_MAX : scaled;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> noise_value <= NOISE_MAX)
        else $error("noise above one");

    a_load_not_query: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_ld_reg && s1_vld_reg) && !(s2_ld_reg && s2_vld_reg))
        else $error("load and query share a stage");

    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg |-> (s5_fade_reg[0] <= ONE_S && s5_fade_reg[1] <= ONE_S
                        && s5_fade_reg[2] <= ONE_S))
        else $error("fade weight above one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(s8_vld_reg) && $stable(s8_res_reg))
        else $error("pipe moved while stalled");

endmodule
